// ===== hw/rtl/rmrc_pkg.sv =====
// Package: codes, widths and register defaults for the reversing motor relay controller.
package rmrc_pkg;

	localparam int MODE_W = 3;
	localparam int CD_W   = 10;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [1:0]        req_t;
	typedef logic [1:0]        cmd_t;

	localparam mode_t MODE_STOP        = 3'd0;
	localparam mode_t MODE_OPEN        = 3'd1;
	localparam mode_t MODE_CLOSE       = 3'd2;
	localparam mode_t MODE_PAUSE_OPEN  = 3'd3;
	localparam mode_t MODE_PAUSE_CLOSE = 3'd4;

	localparam req_t REQ_KEY    = 2'd0;
	localparam req_t REQ_RELAY  = 2'd1;
	localparam req_t REQ_REMOTE = 2'd2;

	localparam cmd_t CMD_OPEN  = 2'd0;
	localparam cmd_t CMD_STOP  = 2'd1;
	localparam cmd_t CMD_CLOSE = 2'd2;

	localparam logic [IDX_W-1:0] REG_PRESS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LONG    = 3'd1;
	localparam logic [IDX_W-1:0] REG_RESTART = 3'd2;
	localparam logic [IDX_W-1:0] REG_PAUSE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_RUN     = 3'd4;

	localparam logic [15:0]     PRESS_RST   = 16'd2;
	localparam logic [15:0]     LONG_RST    = 16'd750;
	localparam logic [15:0]     RESTART_RST = 16'd1500;
	localparam logic [CD_W-1:0] PAUSE_RST   = 10'd5;
	localparam logic [CD_W-1:0] RUN_RST     = 10'd600;

	function automatic mode_t apply_cmd(mode_t mode, cmd_t cmd);
		mode_t r;
		r = mode;
		case (cmd)
			CMD_OPEN: begin
				if (mode == MODE_STOP || mode == MODE_PAUSE_CLOSE)
					r = MODE_OPEN;
				else if (mode == MODE_CLOSE)
					r = MODE_PAUSE_OPEN;
			end
			CMD_STOP: r = MODE_STOP;
			CMD_CLOSE: begin
				if (mode == MODE_STOP || mode == MODE_PAUSE_OPEN)
					r = MODE_CLOSE;
				else if (mode == MODE_OPEN)
					r = MODE_PAUSE_CLOSE;
			end
			default: r = mode;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/reversing_motor_relay_controller.sv =====
// Top level: reversing motor relay controller, key hold counters and relay sequencing.
//
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// s_*      | s_tvalid/s_tready  | tuser req_type, tdata key_levels, remote_cmd
// m_*      | m_tvalid/m_tready  | tdata mode, relays, flash, requests, report
// cfg_*    | cfg_we             | cfg_index, cfg_data
//
// Each word passes an input register and a result register, with a single pass of logic
// between them; one word per cycle is sustained while the result is not stalled.
// After reset the motor is stopped, all counters are zero, the registers hold defaults.
// A stalled result holds the output register; the input stage keeps taking words
// while the result register can advance.
module reversing_motor_relay_controller #(
	parameter int HOLD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // key_levels[2:0], remote_cmd[4:3]
	input  rmrc_pkg::req_t             s_tuser,   // req_type[1:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // motor_mode[2:0], relay_open[3],
	                                              // relay_close[4], flash_leds[5],
	                                              // reset_request[6], restart_request[7],
	                                              // state_report[8]
	input  logic                       cfg_we,
	input  logic [rmrc_pkg::IDX_W-1:0] cfg_index,
	input  logic [rmrc_pkg::CFG_W-1:0] cfg_data
);
	import rmrc_pkg::*;

	localparam int CMP_W = (HOLD_BITS > 16) ? HOLD_BITS : 16;
	localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

	logic [15:0]     press_q, long_q, restart_q;
	logic [CD_W-1:0] pause_q, run_q;

	mode_t                mode_now_q, mode_seen_q;
	logic [CD_W-1:0]      countdown_q;
	logic [HOLD_BITS-1:0] hold_q [3];
	logic                 flash_q;

	logic       valid_s1;
	req_t       req_s1;
	logic [2:0] levels_s1;
	cmd_t       cmd_s1;

	logic       valid_s2;
	logic [8:0] result_s2;

	logic advance, fire_s1;

	mode_t                mode_nx, mode_seen_nx, mode_k;
	logic [CD_W-1:0]      cd_nx, cd_ld;
	logic [HOLD_BITS-1:0] hold_nx [3];
	logic [CMP_W-1:0]     hold_x [3];
	logic                 flash_nx, reset_req, restart_req, report;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire_s1  = valid_s1 && advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, result_s2};

	always_comb begin
		mode_nx      = mode_now_q;
		mode_seen_nx = mode_seen_q;
		cd_nx        = countdown_q;
		cd_ld        = countdown_q;
		flash_nx     = flash_q;
		reset_req    = 1'b0;
		restart_req  = 1'b0;
		report       = 1'b0;
		mode_k       = mode_now_q;
		for (int i = 0; i < 3; i++) begin
			hold_nx[i] = hold_q[i];
		end
		case (req_s1)
			REQ_KEY: begin
				for (int i = 0; i < 3; i++) begin
					if (!levels_s1[i]) begin
						if (hold_q[i] != HOLD_MAX)
							hold_nx[i] = hold_q[i] + 1'b1;
					end else begin
						if (CMP_W'(hold_q[i]) >= CMP_W'(long_q))
							reset_req = 1'b1;
						hold_nx[i] = '0;
					end
				end
				for (int i = 0; i < 3; i++) begin
					hold_x[i] = CMP_W'(hold_nx[i]);
				end
				if (hold_x[0] == CMP_W'(press_q))
					mode_k = apply_cmd(mode_now_q, CMD_OPEN);
				else if (hold_x[1] == CMP_W'(press_q))
					mode_k = apply_cmd(mode_now_q, CMD_STOP);
				else if (hold_x[2] == CMP_W'(press_q))
					mode_k = apply_cmd(mode_now_q, CMD_CLOSE);
				mode_nx     = mode_k;
				flash_nx    = hold_x[0] > CMP_W'(long_q) || hold_x[1] > CMP_W'(long_q)
				              || hold_x[2] > CMP_W'(long_q);
				restart_req = hold_x[0] > CMP_W'(restart_q) && hold_x[1] > CMP_W'(restart_q)
				              && hold_x[2] > CMP_W'(restart_q);
			end
			REQ_RELAY: begin
				if (mode_seen_q != mode_now_q) begin
					mode_seen_nx = mode_now_q;
					report       = 1'b1;
					if (mode_now_q == MODE_OPEN || mode_now_q == MODE_CLOSE)
						cd_ld = run_q;
					else
						cd_ld = pause_q;
				end
				cd_nx = cd_ld;
				if (cd_ld != '0) begin
					cd_nx = cd_ld - 1'b1;
					if (cd_ld == CD_W'(1)) begin
						if (mode_now_q == MODE_PAUSE_CLOSE)
							mode_nx = MODE_CLOSE;
						else if (mode_now_q == MODE_PAUSE_OPEN)
							mode_nx = MODE_OPEN;
						else
							mode_nx = MODE_STOP;
					end
				end
			end
			REQ_REMOTE: mode_nx = apply_cmd(mode_now_q, cmd_s1);
			default: ;
		endcase
		if (req_s1 != REQ_KEY) begin
			for (int i = 0; i < 3; i++) begin
				hold_x[i] = CMP_W'(hold_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= PRESS_RST;
			long_q    <= LONG_RST;
			restart_q <= RESTART_RST;
			pause_q   <= PAUSE_RST;
			run_q     <= RUN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS:   press_q   <= cfg_data;
				REG_LONG:    long_q    <= cfg_data;
				REG_RESTART: restart_q <= cfg_data;
				REG_PAUSE:   pause_q   <= cfg_data[CD_W-1:0];
				REG_RUN:     run_q     <= cfg_data[CD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_now_q  <= MODE_STOP;
			mode_seen_q <= MODE_STOP;
			countdown_q <= '0;
			flash_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				hold_q[i] <= '0;
			end
		end else if (fire_s1) begin
			mode_now_q  <= mode_nx;
			mode_seen_q <= mode_seen_nx;
			countdown_q <= cd_nx;
			flash_q     <= flash_nx;
			for (int i = 0; i < 3; i++) begin
				hold_q[i] <= hold_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1    <= s_tuser;
			levels_s1 <= s_tdata[2:0];
			cmd_s1    <= s_tdata[4:3];
		end
		if (fire_s1)
			result_s2 <= {report, restart_req, reset_req, flash_nx,
			              mode_nx == MODE_CLOSE, mode_nx == MODE_OPEN, mode_nx};
	end

	a_relay_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
		else $error("both relays driven");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_now_q <= MODE_PAUSE_CLOSE)
		else $error("motor mode out of range");

	a_key_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && req_s1 != REQ_KEY) |=> !m_tdata[6] && !m_tdata[7])
		else $error("key request outside key tick");

	a_report_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && req_s1 != REQ_RELAY) |=> !m_tdata[8])
		else $error("state report outside relay tick");

endmodule
